### src/mnde_pkg.sv
// shared types, constants and lookup tables for the midi note to drum event block
// no dependencies
`default_nettype none

package mnde_pkg;

  localparam int NUM_INSTRUMENTS = 16;
  localparam int NUM_KEYS        = 128;
  localparam int KEY_W           = $clog2(NUM_KEYS);

  localparam logic [7:0] MSG_NOTE_ON         = 8'h90;
  localparam logic [7:0] MSG_AFTERTOUCH      = 8'hA0;
  localparam logic [7:0] MSG_CONTROL         = 8'hB0;
  localparam logic [7:0] MSG_TYPE_MASK       = 8'hF0;
  localparam logic [7:0] POSITION_CONTROLLER = 8'd16;
  localparam logic [1:0] FULL_LENGTH         = 2'd3;

  localparam logic [0:0] KIND_ONSET = 1'b0;
  localparam logic [0:0] KIND_CHOKE = 1'b1;

  // instruments above the configured count never fire
  localparam logic [15:0] INST_LIMIT_MASK =
    (NUM_INSTRUMENTS < 16) ? 16'((1 << NUM_INSTRUMENTS) - 1) : 16'hFFFF;

  typedef logic [17:0] q16_table_t [256];

  // (2v-1)/254 in unsigned q16, floored
  function automatic q16_table_t build_vel_table();
    q16_table_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = (i == 0) ? 18'd0 : 18'(((2 * i - 1) * 32768) / 127);
    end
    return t;
  endfunction

  // p/127 in unsigned q16, floored
  function automatic q16_table_t build_pos_table();
    q16_table_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 18'((i * 65536) / 127);
    end
    return t;
  endfunction

  localparam q16_table_t VEL_TABLE = build_vel_table();
  localparam q16_table_t POS_TABLE = build_pos_table();

  typedef struct packed {
    logic        action;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  message_length;
    logic [31:0] sample_offset;
    logic [15:0] map_mask;
  } in_item_t;

  typedef struct packed {
    logic        event_kind;
    logic [3:0]  instrument;
    logic [31:0] event_offset;
    logic [17:0] velocity_q16;
    logic [17:0] position_q16;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_events;
    logic fetch_empty;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

### src/mnde_ifs.sv
// valid/ready stream interfaces for the input messages and the drum events
// depends on mnde_pkg
`default_nettype none

interface mnde_in_if import mnde_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mnde_out_if import mnde_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/mnde_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mnde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/mnde_ctrl.sv
// sequencing fsm: accept, key map fetch, one event per cycle while the output slot is free
// depends on mnde_pkg
`default_nettype none

module mnde_ctrl import mnde_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  dp_status_t      status,
  output logic            in_ready,
  output ctrl_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && status.needs_events) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = status.fetch_empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_EMIT:  cmd.emit  = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### src/mnde_dp.sv
// datapath: message decode, key map store, position cache, event output register
// depends on mnde_pkg and mnde_ram
`default_nettype none

module mnde_dp import mnde_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  in_item_t        in_item,
  input  ctrl_cmd_t       cmd,
  output dp_status_t      status,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_item
);

  logic [NUM_KEYS-1:0] key_valid_r;
  logic [7:0]          position_r;
  logic [7:0]          position_nxt;
  logic                fetch_ok_r;
  logic                kind_r;
  logic [31:0]         offset_r;
  logic [17:0]         vel_r;
  logic [17:0]         pos_r;
  logic [15:0]         mask_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic [KEY_W-1:0]    key_idx;
  logic                key_in_range;
  logic [7:0]          msg_type;
  logic                msg_full;
  logic                is_note;
  logic                is_touch;
  logic                ram_we;
  logic [15:0]         ram_rdata;
  logic [15:0]         fetched_mask;
  logic [15:0]         low_bit;
  logic [3:0]          emit_idx;
  logic                out_free;

  assign key_idx      = in_item.first_data[KEY_W-1:0];
  assign key_in_range = {1'b0, in_item.first_data} < 9'(NUM_KEYS);
  assign msg_type     = in_item.status_byte & MSG_TYPE_MASK;
  assign msg_full     = !in_item.action && (in_item.message_length == FULL_LENGTH);
  assign is_note      = (msg_type == MSG_NOTE_ON) && (in_item.second_data != 8'd0);
  assign is_touch     = (msg_type == MSG_AFTERTOUCH) && (in_item.second_data != 8'd0);
  assign ram_we       = cmd.capture && in_item.action && key_in_range;

  // position: cc16 loads it, any other full message clears it
  always_comb begin
    position_nxt = position_r;
    if (msg_full) begin
      if ((msg_type == MSG_CONTROL) && (in_item.first_data == POSITION_CONTROLLER)) begin
        position_nxt = in_item.second_data;
      end else begin
        position_nxt = 8'd0;
      end
    end
  end

  mnde_ram #(
    .WIDTH (16),
    .DEPTH (NUM_KEYS)
  ) u_key_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_idx),
    .wdata (in_item.map_mask),
    .re    (cmd.capture),
    .raddr (key_idx),
    .rdata (ram_rdata)
  );

  // entries never written read as no instruments
  assign fetched_mask = fetch_ok_r ? (ram_rdata & INST_LIMIT_MASK) : 16'd0;

  assign low_bit = mask_r & (~mask_r + 16'd1);

  always_comb begin
    emit_idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask_r[i]) begin
        emit_idx = 4'(i);
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_valid_r <= '0;
      position_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (ram_we) begin
        key_valid_r[key_idx] <= 1'b1;
      end
      if (cmd.capture) begin
        position_r <= position_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fetch_ok_r <= key_in_range && key_valid_r[key_idx];
      kind_r     <= is_touch ? KIND_CHOKE : KIND_ONSET;
      offset_r   <= in_item.sample_offset;
      vel_r      <= is_touch ? 18'd0 : VEL_TABLE[in_item.second_data];
      pos_r      <= is_touch ? 18'd0 : POS_TABLE[position_r];
    end
    if (cmd.fetch) begin
      mask_r <= fetched_mask;
    end else if (cmd.emit) begin
      mask_r <= mask_r & ~low_bit;
    end
    if (cmd.emit) begin
      out_item_r.event_kind   <= kind_r;
      out_item_r.instrument   <= emit_idx;
      out_item_r.event_offset <= offset_r;
      out_item_r.velocity_q16 <= vel_r;
      out_item_r.position_q16 <= pos_r;
      out_item_r.last_of_run  <= ((mask_r & ~low_bit) == 16'd0);
    end
  end

  assign status.needs_events = msg_full && (is_note || is_touch);
  assign status.fetch_empty  = (fetched_mask == 16'd0);
  assign status.out_free     = out_free;
  assign status.emit_last    = ((mask_r & ~low_bit) == 16'd0);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // an event is only ever taken from a non-empty run
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (mask_r != 16'd0))
    else $error("event emitted from empty instrument mask");

  // the emitted instrument is retired from the run
  a_emit_retires: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !mask_r[$past(emit_idx)])
    else $error("emitted instrument still pending");

  // the output slot is never overwritten while an event waits
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("event loaded over a pending event");

endmodule

`default_nettype wire

### src/midi_note_to_drum_events_core.sv
// top level of the midi note to drum event decoder
// depends on mnde_pkg, mnde_ifs, mnde_ram, mnde_ctrl and mnde_dp
`default_nettype none

// channel   dir  handshake            transaction
// in_ch     in   valid/ready          one midi message or one key map write
// out_ch    out  valid/ready          one onset or choke event
//
// map writes, short messages and event-free messages are accepted in idle, which the fsm does not leave
// a note on or aftertouch with mapped instruments runs in steps: accept the message
// and read the key map ram, load the registered read into the instrument mask, then
// one event a cycle through the output register while the sink keeps ready high
// synchronous active-low reset clears the per-key valid bits, so the whole map
// reads as empty right away, with no clearing pass
// a stalled sink holds the event in the output register and pauses the run

module midi_note_to_drum_events_core import mnde_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mnde_in_if.sink    in_ch,
  mnde_out_if.source out_ch
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  // fsm: idle -> fetch -> emit, back to idle after the last event is loaded, or from fetch if none is mapped
  mnde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // decode, key map, position cache and event register
  mnde_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.data)
  );

  // ready only while idle; the last event may still be waiting downstream
  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

### sim/mnde_tb_pkg.sv
// scoreboard for the midi note to drum event decoder: predicts events per message
// and checks the events that leave the block in order
// depends on mnde_pkg

package mnde_tb_pkg;
  import mnde_pkg::*;

  localparam logic [7:0] MSG_NOTE_OFF = 8'h80;
  localparam logic [7:0] MSG_SYSTEM   = 8'hF0;
  localparam int         LANE_COUNT   = (NUM_INSTRUMENTS < 16) ? NUM_INSTRUMENTS : 16;
  localparam int         REPORT_LIMIT = 10;

  class drum_event_scoreboard;
    logic [15:0] instrument_map [NUM_KEYS];
    logic [7:0]  held_position;
    out_item_t   expected_events [$];
    int          error_count;
    int          messages_noted;
    int          onsets_seen;
    int          chokes_seen;

    function new();
      foreach (instrument_map[k]) instrument_map[k] = '0;
      held_position  = '0;
      error_count    = 0;
      messages_noted = 0;
      onsets_seen    = 0;
      chokes_seen    = 0;
    endfunction

    // one accepted input transaction: update the map and position, queue its events
    function void note_message(in_item_t m);
      logic [15:0] hits;
      logic [17:0] vel;
      logic [17:0] pos;
      logic        kind;
      logic        emits;
      int          last_lane;
      out_item_t   ev;
      messages_noted++;
      if (m.action) begin
        if (m.first_data < NUM_KEYS) instrument_map[m.first_data] = m.map_mask;
        return;
      end
      if (m.message_length < FULL_LENGTH) return;
      emits = 1'b0;
      kind  = KIND_ONSET;
      vel   = '0;
      pos   = '0;
      case (m.status_byte & MSG_TYPE_MASK)
        MSG_NOTE_ON: begin
          if (m.second_data != 0) begin
            emits = 1'b1;
            vel   = 18'(((2 * int'(m.second_data) - 1) * 32768) / 127);
            pos   = 18'((int'(held_position) * 65536) / 127);
          end
        end
        MSG_AFTERTOUCH: begin
          if (m.second_data != 0) begin
            emits = 1'b1;
            kind  = KIND_CHOKE;
          end
        end
        MSG_CONTROL: begin
          if (m.first_data == POSITION_CONTROLLER) begin
            held_position = m.second_data;
            return;
          end
        end
        default: ;
      endcase
      held_position = '0;
      if (!emits || m.first_data >= NUM_KEYS) return;
      hits      = instrument_map[m.first_data];
      last_lane = -1;
      for (int i = 0; i < LANE_COUNT; i++) if (hits[i]) last_lane = i;
      for (int i = 0; i < LANE_COUNT; i++) begin
        if (hits[i]) begin
          ev.event_kind   = kind;
          ev.instrument   = 4'(i);
          ev.event_offset = m.sample_offset;
          ev.velocity_q16 = vel;
          ev.position_q16 = pos;
          ev.last_of_run  = (i == last_lane);
          expected_events = {expected_events, ev};
        end
      end
    endfunction

    function void check_event(out_item_t got);
      out_item_t want;
      if (got.event_kind == KIND_CHOKE) chokes_seen++;
      else onsets_seen++;
      if (expected_events.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected event: kind=%0d inst=%0d off=%h vel=%0d pos=%0d last=%0b",
                   got.event_kind, got.instrument, got.event_offset, got.velocity_q16,
                   got.position_q16, got.last_of_run);
        return;
      end
      want = expected_events.pop_front();
      if (got.event_kind !== want.event_kind || got.instrument !== want.instrument ||
          got.event_offset !== want.event_offset || got.velocity_q16 !== want.velocity_q16 ||
          got.position_q16 !== want.position_q16 || got.last_of_run !== want.last_of_run) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("event mismatch: expected kind=%0d inst=%0d off=%h vel=%0d pos=%0d last=%0b",
                   want.event_kind, want.instrument, want.event_offset, want.velocity_q16,
                   want.position_q16, want.last_of_run);
          $display("                actual   kind=%0d inst=%0d off=%h vel=%0d pos=%0d last=%0b",
                   got.event_kind, got.instrument, got.event_offset, got.velocity_q16,
                   got.position_q16, got.last_of_run);
        end
      end
    endfunction

    function int outstanding();
      return expected_events.size();
    endfunction

    // anything still queued at the end never came out
    function void close_out();
      if (expected_events.size() != 0) begin
        $display("%0d expected events never arrived", expected_events.size());
        error_count += expected_events.size();
        expected_events.delete();
      end
    endfunction
  endclass

endpackage

### sim/tb_top.sv
// self-checking testbench for midi_note_to_drum_events_core: directed and random
// midi messages and key map writes, events checked by a scoreboard
// depends on mnde_pkg, mnde_ifs, mnde_tb_pkg and the block's rtl

module tb_top;
  import mnde_pkg::*;
  import mnde_tb_pkg::*;

  // no-transaction cycles before the run is declared hung; the longest legal quiet
  // stretch is the forced output hold plus one run of events
  localparam int IDLE_LIMIT       = 5000;
  // linger after the final drain
  localparam int DRAIN_CYCLES     = 24;
  localparam int RANDOM_PER_PHASE = 75;
  localparam int LONG_HOLD        = 300;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  mnde_in_if  in_ch ();
  mnde_out_if out_ch ();

  midi_note_to_drum_events_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  drum_event_scoreboard events_sb;

  int sender_idle_pct;
  int receiver_idle_pct;
  int hold_requests;
  int holds_served = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  int counted_items;

  // ---------------------------------------------------------------------------
  // event sink: random ready, plus a long forced hold whenever one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      // start of a long hold, the sender keeps offering so the block backs up
      holds_served = hold_requests;
      hold_left    = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every transaction on both channels goes to the scoreboard, and a
  // watchdog counts cycles in which nothing moved
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) events_sb.check_event(out_ch.data);
      if (in_ch.valid && in_ch.ready) events_sb.note_message(in_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // all fields random, offsets lean on their extremes now and then
  function automatic in_item_t noise_item();
    in_item_t m;
    int       r;
    m.action         = 1'($urandom_range(1));
    m.status_byte    = 8'($urandom_range(255));
    m.first_data     = 8'($urandom_range(255));
    m.second_data    = 8'($urandom_range(255));
    m.message_length = 2'($urandom_range(3));
    m.map_mask       = 16'($urandom_range(65535));
    r = $urandom_range(19);
    if (r == 0) m.sample_offset = '0;
    else if (r == 1) m.sample_offset = '1;
    else m.sample_offset = $urandom();
    return m;
  endfunction

  // full-length channel message on a random channel, unused fields left random
  function automatic in_item_t well_formed(input logic [7:0] msg_type, input logic [7:0] d1,
                                           input logic [7:0] d2);
    in_item_t m;
    m = noise_item();
    m.action         = 1'b0;
    m.message_length = FULL_LENGTH;
    m.status_byte    = (msg_type & MSG_TYPE_MASK) | 8'($urandom_range(15));
    m.first_data     = d1;
    m.second_data    = d2;
    return m;
  endfunction

  function automatic in_item_t map_write(input logic [7:0] key, input logic [15:0] mask);
    in_item_t m;
    m = noise_item();
    m.action     = 1'b1;
    m.first_data = key;
    m.map_mask   = mask;
    return m;
  endfunction

  // mostly a small key set so notes hit written entries, sometimes keys past the map
  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 8) return 8'($urandom_range(15));
    if (r == 8) return 8'd127;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'd1;
    if (r == 3) return 8'd127;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_mask();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 4) return 16'(1 << $urandom_range(15));
    return 16'($urandom_range(65535));
  endfunction

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------

  // offer one input transaction, with random idle cycles ahead of it
  task automatic send_message(input in_item_t m);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // ignored transactions (short messages, writes past the map) do not count
    if (m.action ? (m.first_data < NUM_KEYS) : (m.message_length >= FULL_LENGTH))
      counted_items++;
  endtask

  // stop offering until every predicted event is out, then optionally linger
  task automatic wait_for_drain(input int linger);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (events_sb.outstanding() != 0) @(posedge clk);
    repeat (linger) @(posedge clk);
  endtask

  // fully mapped key hammered while the sink holds off, so the block stalls its input
  task automatic stall_burst(input int count);
    send_message(map_write(8'd0, 16'hFFFF));
    hold_requests <= hold_requests + 1;
    repeat (count) send_message(well_formed(MSG_NOTE_ON, 8'd0, pick_value()));
  endtask

  // mostly well-formed traffic with random content, the rest broken or pure noise
  task automatic send_random_traffic(input int quota);
    int       base_count;
    int       pick;
    in_item_t m;
    base_count = counted_items;
    while (counted_items - base_count < quota) begin
      pick = $urandom_range(99);
      m    = noise_item();
      if (pick < 14) begin
        m = map_write(pick_key(), pick_mask());
      end else if (pick < 30) begin
        // position set, then a note that picks it up
        send_message(well_formed(MSG_CONTROL, POSITION_CONTROLLER, pick_value()));
        m = well_formed(MSG_NOTE_ON, pick_key(), pick_value());
      end else if (pick < 55) begin
        m = well_formed(MSG_NOTE_ON, pick_key(), pick_value());
      end else if (pick < 68) begin
        m = well_formed(MSG_AFTERTOUCH, pick_key(), pick_value());
      end else if (pick < 78) begin
        // any message type, any controller
        m = well_formed(8'($urandom_range(15) << 4), 8'($urandom_range(255)), pick_value());
      end else if (pick < 86) begin
        // position followed by a truncated note
        send_message(well_formed(MSG_CONTROL, POSITION_CONTROLLER, pick_value()));
        m = well_formed(MSG_NOTE_ON, pick_key(), pick_value());
        m.message_length = 2'($urandom_range(2));
      end
      send_message(m);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t m;
    events_sb         = new();
    in_ch.valid       = 1'b0;
    in_ch.data        = '0;
    sender_idle_pct   = 8;
    receiver_idle_pct = 81;
    hold_requests     = 0;
    counted_items     = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: the map is empty right after reset
    send_message(well_formed(MSG_NOTE_ON, 8'd60, 8'd100));
    send_message(map_write(8'd0, 16'hFFFF));
    send_message(map_write(8'd127, 16'h8001));
    // writes past the last key are dropped
    send_message(map_write(8'd128, 16'h00FF));
    send_message(map_write(8'd255, 16'h5555));
    send_message(map_write(8'd60, 16'h0010));
    // full run of sixteen onsets at the top velocity and position
    send_message(well_formed(MSG_CONTROL, POSITION_CONTROLLER, 8'd127));
    m = well_formed(MSG_NOTE_ON, 8'd0, 8'd127);
    m.sample_offset = '1;
    send_message(m);
    // position was cleared by the onset message, lowest velocity
    send_message(well_formed(MSG_NOTE_ON, 8'd127, 8'd1));
    // position survives a map write and a short message
    send_message(well_formed(MSG_CONTROL, POSITION_CONTROLLER, 8'd255));
    send_message(map_write(8'd1, 16'h0000));
    m = well_formed(MSG_CONTROL, POSITION_CONTROLLER, 8'd9);
    m.message_length = 2'd2;
    send_message(m);
    m = well_formed(MSG_NOTE_ON, 8'd60, 8'd255);
    m.sample_offset = '0;
    send_message(m);
    // zero velocity emits nothing but clears the position
    send_message(well_formed(MSG_CONTROL, POSITION_CONTROLLER, 8'd64));
    send_message(well_formed(MSG_NOTE_ON, 8'd0, 8'd0));
    send_message(well_formed(MSG_NOTE_ON, 8'd60, 8'd50));
    // key past the map
    send_message(well_formed(MSG_CONTROL, POSITION_CONTROLLER, 8'd33));
    send_message(well_formed(MSG_NOTE_ON, 8'd200, 8'd90));
    // chokes, then zero pressure
    send_message(well_formed(MSG_AFTERTOUCH, 8'd0, 8'd1));
    send_message(well_formed(MSG_AFTERTOUCH, 8'd127, 8'd0));
    // note off, other controller and system messages all clear the position
    send_message(well_formed(MSG_CONTROL, POSITION_CONTROLLER, 8'd33));
    send_message(well_formed(MSG_NOTE_OFF, 8'd0, 8'd64));
    send_message(well_formed(MSG_NOTE_ON, 8'd60, 8'd64));
    send_message(well_formed(MSG_CONTROL, 8'd7, 8'd100));
    send_message(well_formed(MSG_SYSTEM, 8'd0, 8'd127));
    m = well_formed(MSG_NOTE_ON, 8'd0, 8'd127);
    m.message_length = 2'd0;
    send_message(m);

    // phase 1: sender mostly busy, sink mostly stalled
    send_random_traffic(RANDOM_PER_PHASE);
    stall_burst(12);
    wait_for_drain(0);

    // phase 2: sender mostly idle, sink mostly ready
    sender_idle_pct = 81;
    receiver_idle_pct <= 8;
    send_random_traffic(RANDOM_PER_PHASE);
    wait_for_drain(0);

    // phase 3: back to back on both sides
    sender_idle_pct = 0;
    receiver_idle_pct <= 0;
    stall_burst(20);
    send_random_traffic(RANDOM_PER_PHASE);

    wait_for_drain(DRAIN_CYCLES);
    events_sb.close_out();

    $display("covered %0d input transactions, %0d onsets and %0d chokes checked",
             events_sb.messages_noted, events_sb.onsets_seen, events_sb.chokes_seen);
    $display("three idle mixes, %0d long sink holds, %0d mismatches",
             holds_served, events_sb.error_count);
    if (events_sb.error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
